// ===== rtl/bhs_pkg.sv =====
// Shared types, constants and state codes for the bucketed hash set.
// No dependencies; every other file imports this package.
`default_nettype none

package bhs_pkg;

   localparam int KEY_W       = 32;
   localparam int CSR_W       = 9;
   localparam int STATUS_W    = 3;
   localparam int INDEX_OUT_W = 8;
   localparam int HASH_SHIFT  = 2;

   localparam int DEF_BUCKETS = 256;
   localparam int DEF_WAYS    = 4;

   localparam logic [CSR_W-1:0] BUCKET_COUNT_RESET = 9'd256;

   // remainder unit: quotient bits retired per cycle
   localparam int DIV_BITS   = 4;
   localparam int DIV_CYCLES = KEY_W / DIV_BITS;
   localparam int STEP_W     = $clog2(DIV_CYCLES);

   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic             operation;
      logic [KEY_W-1:0] key;
   } bhs_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [INDEX_OUT_W-1:0] bucket_index;
   } bhs_rsp_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIVIDE,
      F_HANDOFF
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_EVAL
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/bhs_queue.sv =====
// Small two-entry queue used between the front and back stages and at the output.
// Depends on bhs_pkg for the depth.
`default_nettype none

module bhs_queue #(
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);
   import bhs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bhs_front.sv =====
// Front stage: takes a request and reduces (key >> 2) modulo the bucket count
// with a radix-16 restoring remainder unit. Depends on bhs_pkg.
`default_nettype none

module bhs_front #(
   parameter int BUCKETS = bhs_pkg::DEF_BUCKETS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  bhs_pkg::bhs_req_type                   req,
   input  logic [$clog2(BUCKETS+1)-1:0]           divisor,
   output logic                                   idle,
   output logic                                   q_push,
   output logic                                   q_operation,
   output logic [bhs_pkg::KEY_W-1:0]              q_key,
   output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] q_bucket,
   input  logic                                   q_full
);
   import bhs_pkg::*;

   localparam int CNT_W = $clog2(BUCKETS + 1);
   localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   front_state_type  state_ff, state_in;
   logic [STEP_W-1:0] step_ff;
   logic             operation_ff;
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] dividend_ff, dividend_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W:0]   trial;
   logic             load, run, last_step;

   assign last_step = (step_ff == STEP_W'(DIV_CYCLES - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:    if (start) state_in = F_DIVIDE;
         F_DIVIDE:  if (last_step) state_in = F_HANDOFF;
         F_HANDOFF: if (!q_full) state_in = F_IDLE;
         default:   state_in = F_IDLE;
      endcase
   end

   always_comb begin
      idle   = 1'b0;
      load   = 1'b0;
      run    = 1'b0;
      q_push = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            idle = 1'b1;
            load = start;
         end
         F_DIVIDE:  run = 1'b1;
         F_HANDOFF: q_push = !q_full;
         default:   idle = 1'b0;
      endcase
   end

   // DIV_BITS restoring steps per cycle; remainder stays below the divisor
   always_comb begin
      rem_in      = rem_ff;
      dividend_in = dividend_ff;
      trial       = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial       = {rem_in, dividend_in[KEY_W-1]};
         dividend_in = {dividend_in[KEY_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in = trial[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         operation_ff <= req.operation;
         key_ff       <= req.key;
         dividend_ff  <= req.key >> HASH_SHIFT;
         rem_ff       <= '0;
         step_ff      <= '0;
      end else if (run) begin
         dividend_ff <= dividend_in;
         rem_ff      <= rem_in;
         step_ff     <= step_ff + 1'b1;
      end
   end

   assign q_operation = operation_ff;
   assign q_key       = key_ff;
   assign q_bucket    = IDX_W'(rem_ff);

endmodule

`default_nettype wire

// ===== rtl/bhs_back.sv =====
// Back stage: bucket row memory, clearing pass after reset, and the
// read-compare-write of one bucket per request. Depends on bhs_pkg.
`default_nettype none

module bhs_back #(
   parameter int BUCKETS = bhs_pkg::DEF_BUCKETS,
   parameter int WAYS    = bhs_pkg::DEF_WAYS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic                                   in_operation,
   input  logic [bhs_pkg::KEY_W-1:0]              in_key,
   input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] in_bucket,
   output logic                                   in_pop,
   output logic                                   clearing,
   output logic                                   out_push,
   output bhs_pkg::bhs_rsp_type                   out_data,
   input  logic                                   out_full
);
   import bhs_pkg::*;

   localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   logic [WAYS*KEY_W-1:0] mem_keys  [BUCKETS];
   logic [WAYS-1:0]       mem_valid [BUCKETS];

   back_state_type        state_ff, state_in;
   logic [IDX_W-1:0]      clr_ff;
   logic                  operation_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [IDX_W-1:0]      bucket_ff;
   logic [WAYS*KEY_W-1:0] rd_keys_ff;
   logic [WAYS-1:0]       rd_valid_ff;

   logic                  clear_last, fire, keys_we, valid_we;
   logic [IDX_W-1:0]      valid_addr;
   logic [WAYS-1:0]       valid_wdata;
   logic [WAYS-1:0]       hit, free, hit_one, free_one, new_valid;
   logic [WAYS*KEY_W-1:0] new_keys;
   logic                  found, have_free;
   logic [STATUS_W-1:0]   status;

   assign clear_last = (clr_ff == IDX_W'(BUCKETS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: if (clear_last) state_in = B_IDLE;
         B_IDLE:  if (in_valid) state_in = B_EVAL;
         B_EVAL:  if (!out_full) state_in = B_IDLE;
         default: state_in = B_CLEAR;
      endcase
   end

   always_comb begin
      clearing = 1'b0;
      in_pop   = 1'b0;
      fire     = 1'b0;
      unique case (state_ff)
         B_CLEAR: clearing = 1'b1;
         B_IDLE:  in_pop = in_valid;
         B_EVAL:  fire = !out_full;
         default: clearing = 1'b0;
      endcase
   end

   // way match and free search on the registered row
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit[w] = rd_valid_ff[w] && (rd_keys_ff[w*KEY_W +: KEY_W] == key_ff);
      end
      free      = ~rd_valid_ff;
      hit_one   = hit & (~hit + WAYS'(1));
      free_one  = free & (~free + WAYS'(1));
      found     = |hit;
      have_free = |free;
   end

   always_comb begin
      new_valid = rd_valid_ff;
      keys_we   = 1'b0;
      case (operation_ff)
         OP_ADD: begin
            if (found) begin
               status = ST_PRESENT;
            end else if (have_free) begin
               status    = ST_INSERTED;
               new_valid = rd_valid_ff | free_one;
               keys_we   = fire;
            end else begin
               status = ST_FULL;
            end
         end
         OP_REMOVE: begin
            if (found) begin
               status    = ST_REMOVED;
               new_valid = rd_valid_ff & ~hit_one;
            end else begin
               status = ST_NOT_FOUND;
            end
         end
         default: status = ST_NOT_FOUND;
      endcase
      for (int w = 0; w < WAYS; w++) begin
         new_keys[w*KEY_W +: KEY_W] = free_one[w] ? key_ff : rd_keys_ff[w*KEY_W +: KEY_W];
      end
   end

   assign valid_we    = clearing || fire;
   assign valid_addr  = clearing ? clr_ff : bucket_ff;
   assign valid_wdata = clearing ? '0 : new_valid;

   assign out_push              = fire;
   assign out_data.status       = status;
   assign out_data.bucket_index = INDEX_OUT_W'(bucket_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop) begin
         operation_ff <= in_operation;
         key_ff       <= in_key;
         bucket_ff    <= in_bucket;
      end
   end

   always_ff @(posedge clock) begin
      if (keys_we) begin
         mem_keys[bucket_ff] <= new_keys;
      end
      if (in_pop) begin
         rd_keys_ff <= mem_keys[in_bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (valid_we) begin
         mem_valid[valid_addr] <= valid_wdata;
      end
      if (in_pop) begin
         rd_valid_ff <= mem_valid[in_bucket];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bucketed_hash_set_core.sv =====
// Bucketed hash set: a set of 32-bit keys in BUCKETS rows of WAYS ways.
// Channels: requests enter on req_push/req_full with req_data (operation, key);
// results leave on rsp_empty/rsp_pop with rsp_data (status, bucket_index), one
// result per request, in request order. csr_valid/csr_ready/csr_data writes the
// bucket count; csr_ready is always high. Write it only while the block is idle.
// Bucket is (key >> 2) mod the bucket count (0 acts as 1, above BUCKETS as BUCKETS).
// An accepted request passes the 4-bit-per-cycle remainder unit, a handoff state,
// the registered row read and then compare and write-back. The front stage takes
// a new request only after it has handed the last one off; the back stage's row
// read-modify-write overlaps with the next request's division.
// Reset: a clearing pass marks every one of the BUCKETS rows (256 at the default)
// empty, one row a cycle; req_full stays high until it ends.
// Receiver stall: results wait in a two-entry output queue, the back stage then
// holds one, two more wait in the middle queue and the front stage parks a
// sixth after its division, after which req_full stays high.
// Depends on bhs_pkg, bhs_queue, bhs_front and bhs_back.
`default_nettype none

module bucketed_hash_set_core #(
   parameter int BUCKETS = bhs_pkg::DEF_BUCKETS,
   parameter int WAYS    = bhs_pkg::DEF_WAYS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  bhs_pkg::bhs_req_type        req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output bhs_pkg::bhs_rsp_type        rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bhs_pkg::CSR_W-1:0]   csr_data
);
   import bhs_pkg::*;

   localparam int CNT_W = $clog2(BUCKETS + 1);
   localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   typedef struct packed {
      logic             operation;
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] bucket;
   } mid_item_type;

   logic [CSR_W-1:0] bucket_count_ff;
   logic [CNT_W-1:0] divisor;
   logic             start, front_idle, clearing;
   mid_item_type     mid_push_data, mid_pop_data;
   logic             mid_push, mid_full, mid_pop, mid_empty;
   bhs_rsp_type      back_rsp;
   logic             out_push, out_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         bucket_count_ff <= csr_data;
      end
   end

   always_comb begin
      if (bucket_count_ff == '0) begin
         divisor = CNT_W'(1);
      end else if (32'(bucket_count_ff) > 32'(BUCKETS)) begin
         divisor = CNT_W'(BUCKETS);
      end else begin
         divisor = CNT_W'(bucket_count_ff);
      end
   end

   assign req_full = !front_idle || clearing;
   assign start    = req_push && !req_full;

   bhs_front #(
      .BUCKETS (BUCKETS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req_data),
      .divisor     (divisor),
      .idle        (front_idle),
      .q_push      (mid_push),
      .q_operation (mid_push_data.operation),
      .q_key       (mid_push_data.key),
      .q_bucket    (mid_push_data.bucket),
      .q_full      (mid_full)
   );

   bhs_queue #(
      .item_type (mid_item_type)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_push_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty)
   );

   bhs_back #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (!mid_empty),
      .in_operation (mid_pop_data.operation),
      .in_key       (mid_pop_data.key),
      .in_bucket    (mid_pop_data.bucket),
      .in_pop       (mid_pop),
      .clearing     (clearing),
      .out_push     (out_push),
      .out_data     (back_rsp),
      .out_full     (out_full)
   );

   bhs_queue #(
      .item_type (bhs_rsp_type)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

`default_nettype wire

// ===== rtl/bhs_checker.sv =====
// Port-level checks for bucketed_hash_set_core, attached by bind.
// Depends on bhs_pkg and the top level's port list.
`default_nettype none

module bhs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_push,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input bhs_pkg::bhs_rsp_type rsp_data
);
   import bhs_pkg::*;

   // clearing pass blocks requests right after reset
   a_reset_blocks_req: assert property (@(posedge clock) reset |=> req_full)
      else $error("request side open right after reset");

   a_reset_empties_rsp: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending right after reset");

   // one request at a time in the remainder unit
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("request side open while a request is being divided");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.status <= ST_FULL))
      else $error("undefined status code");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

endmodule

bind bucketed_hash_set_core bhs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== test/bucketed_hash_set_core_tb.sv =====
// Self-checking testbench for bucketed_hash_set_core: add/remove requests with
// a set model kept in the scoreboard, bucket count changed between phases.
// Depends on bhs_pkg and the bucketed_hash_set_core RTL.
`default_nettype none

module bucketed_hash_set_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bhs_pkg::*;

   localparam int BUCKETS     = DEF_BUCKETS;
   localparam int WAYS        = DEF_WAYS;
   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_ITEMS = 55;
   localparam int POOL_SIZE   = 10;

   // set model plus the queue of responses still owed by the block
   class hash_set_scoreboard;
      logic [KEY_W-1:0] stored_key [BUCKETS*WAYS];
      bit               occupied [BUCKETS*WAYS];
      logic [CSR_W-1:0] bucket_count;
      bhs_rsp_type      expected_rsp_q [$];
      int               errors;

      function void clear();
         foreach (occupied[i]) begin
            occupied[i]   = 1'b0;
            stored_key[i] = '0;
         end
         bucket_count = BUCKET_COUNT_RESET;
         errors       = 0;
      endfunction

      function void set_bucket_count(logic [CSR_W-1:0] value);
         bucket_count = value;
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      function void note_request(bhs_req_type req);
         int unsigned modulus;
         int unsigned bucket;
         int          hit_slot;
         int          free_slot;
         bhs_rsp_type rsp;
         modulus = bucket_count;
         if (modulus == 0) modulus = 1;
         if (modulus > BUCKETS) modulus = BUCKETS;
         bucket    = (int'(req.key >> HASH_SHIFT) & 32'h3FFF_FFFF) % modulus;
         hit_slot  = -1;
         free_slot = -1;
         for (int w = 0; w < WAYS; w++) begin
            if (occupied[bucket*WAYS + w]) begin
               if (hit_slot < 0 && stored_key[bucket*WAYS + w] == req.key)
                  hit_slot = bucket*WAYS + w;
            end else if (free_slot < 0) begin
               free_slot = bucket*WAYS + w;
            end
         end
         if (req.operation == OP_ADD) begin
            if (hit_slot >= 0) begin
               rsp.status = ST_PRESENT;
            end else if (free_slot >= 0) begin
               stored_key[free_slot] = req.key;
               occupied[free_slot]   = 1'b1;
               rsp.status = ST_INSERTED;
            end else begin
               rsp.status = ST_FULL;
            end
         end else begin
            if (hit_slot >= 0) begin
               occupied[hit_slot] = 1'b0;
               rsp.status = ST_REMOVED;
            end else begin
               rsp.status = ST_NOT_FOUND;
            end
         end
         rsp.bucket_index = bucket[INDEX_OUT_W-1:0];
         expected_rsp_q.push_back(rsp);
      endfunction

      function void check_result(bhs_rsp_type got);
         bhs_rsp_type exp;
         if (expected_rsp_q.size() == 0) begin
            errors++;
            if (errors <= 50)
               $display("%0t: unexpected response status=%0d bucket=%0d",
                        $time, got.status, got.bucket_index);
            return;
         end
         exp = expected_rsp_q.pop_front();
         if (got.status !== exp.status) begin
            errors++;
            if (errors <= 50)
               $display("%0t: status mismatch expected=%0d actual=%0d",
                        $time, exp.status, got.status);
         end
         if (got.bucket_index !== exp.bucket_index) begin
            errors++;
            if (errors <= 50)
               $display("%0t: bucket_index mismatch expected=%0d actual=%0d",
                        $time, exp.bucket_index, got.bucket_index);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   bhs_req_type      req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   bhs_rsp_type      rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   hash_set_scoreboard sb = new();
   logic [KEY_W-1:0]   key_pool [POOL_SIZE];

   bucketed_hash_set_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // response side: check on accept, then pick the pop for the next cycle
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_pop && rsp_empty === 1'b0)
            sb.check_result(rsp_data);
         rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog: cycles in which no request, response or csr write moves
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && req_full === 1'b0) || (rsp_pop && rsp_empty === 1'b0) ||
             (csr_valid && csr_ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic send_request(input logic operation, input logic [KEY_W-1:0] key);
      bhs_req_type req;
      req.operation = operation;
      req.key       = key;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_data <= req;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full !== 1'b0);
      sb.note_request(req);
   endtask

   task automatic drain_responses();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_bucket_count(input logic [CSR_W-1:0] value);
      drain_responses();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      sb.set_bucket_count(value);
   endtask

   // pool keys land in the first few buckets so collisions and full rows occur
   function automatic logic [KEY_W-1:0] clustered_key(int unsigned modulus);
      longint unsigned mult;
      longint unsigned bucket;
      mult   = $urandom_range(0, (32'h4000_0000 / modulus) - 1);
      bucket = $urandom_range(0, (modulus < 4) ? modulus - 1 : 3);
      return KEY_W'(((bucket + modulus * mult) << HASH_SHIFT) | $urandom_range(0, 3));
   endfunction

   task automatic run_phase(input logic [CSR_W-1:0] count, input int idle_mode);
      int unsigned modulus;
      logic        operation;
      logic [KEY_W-1:0] key;
      modulus = count;
      if (modulus == 0) modulus = 1;
      if (modulus > BUCKETS) modulus = BUCKETS;
      write_bucket_count(count);
      case (idle_mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
         default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      foreach (key_pool[i]) key_pool[i] = clustered_key(modulus);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         operation = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_REMOVE;
         if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            key = $urandom();
         send_request(operation, key);
      end
   endtask

   initial begin
      sb.clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: duplicates, misses, a full row, way reuse, extreme keys
      send_request(OP_ADD,    32'h0000_0000);
      send_request(OP_ADD,    32'h0000_0000);
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_ADD,    32'hFFFF_FFFF);
      send_request(OP_ADD,    32'h0000_0004);
      send_request(OP_ADD,    32'h0000_0005);
      send_request(OP_ADD,    32'h0000_0006);
      send_request(OP_ADD,    32'h0000_0007);
      send_request(OP_ADD,    32'h8000_0004);
      send_request(OP_ADD,    32'h0000_0005);
      send_request(OP_REMOVE, 32'h0000_0006);
      send_request(OP_ADD,    32'h8000_0004);
      send_request(OP_REMOVE, 32'h7FFF_FFFF);
      send_request(OP_ADD,    32'h7FFF_FFFF);
      send_request(OP_REMOVE, 32'hFFFF_FFFF);
      send_request(OP_ADD,    32'h0000_0400);
      send_request(OP_REMOVE, 32'h0000_0400);

      // table is kept across phases, so old keys may sit under a stale modulus
      run_phase(9'd1,   0);
      run_phase(9'd0,   1);
      run_phase(9'd3,   2);
      run_phase(9'd511, 3);
      run_phase(9'd7,   0);
      run_phase(9'd300, 1);
      run_phase(9'd64,  2);
      run_phase(9'd2,   3);
      run_phase(9'd256, 0);

      drain_responses();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
